// ----- sv/assert_macros.svh -----
// Assertion helpers used by the RTL file pkbs_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PKBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pkbs assertion failed");

// next-cycle implication, disabled in reset
`define PKBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pkbs assertion failed");

`endif

// ----- sv/pkbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pkbs_pkg
// Types, codes and tables shared by the power key / battery supervisor.
// ----------------------------------------------------------------------------
package pkbs_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  // button modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_OFF   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_HOLD_OFF      = 3'd0;
  localparam logic [2:0] REG_HOLD_AIRPLANE = 3'd1;
  localparam logic [2:0] REG_RELEASE_RESET = 3'd2;
  localparam logic [2:0] REG_SHUTDOWN_THR  = 3'd3;
  localparam logic [2:0] REG_FADE_PERIOD   = 3'd4;

  localparam int          CFG_AW      = 3;
  localparam int          CFG_DW      = 16;
  localparam int          DIV_W       = 16;
  localparam logic [3:0]  TIME_LIGHTS = 4'd5;
  localparam logic [3:0]  BAR_FIRST   = 4'd10;
  localparam logic [7:0]  LIGHT_ON    = 8'd120;
  localparam logic [7:0]  TOP_LEVEL   = 8'd43;
  localparam logic [10:0] FULL_SCALE  = 11'd1275;
  // 2^18/5 rounded up, exact for 16-bit dividends
  localparam logic [15:0] RECIP_5     = 16'd52429;

  // 1275 / (43 - t) for t below 43, full scale above
  localparam logic [10:0] SCALE_TAB [64] = '{
    11'd29,  11'd30,  11'd31,  11'd31,  11'd32,  11'd33,  11'd34,  11'd35,
    11'd36,  11'd37,  11'd38,  11'd39,  11'd41,  11'd42,  11'd43,  11'd45,
    11'd47,  11'd49,  11'd51,  11'd53,  11'd55,  11'd57,  11'd60,  11'd63,
    11'd67,  11'd70,  11'd75,  11'd79,  11'd85,  11'd91,  11'd98,  11'd106,
    11'd115, 11'd127, 11'd141, 11'd159, 11'd182, 11'd212, 11'd255, 11'd318,
    11'd425, 11'd637, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275,
    11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275,
    11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275, 11'd1275
  };

  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic prep;      // compute step and bar amount, load divider
    logic div_step;  // one quotient bit
    logic advance;   // result item taken this cycle
  } cmd_t;

  typedef struct packed {
    logic show_new;  // item being accepted emits a frame
    logic last;      // current result is the final one of the item
    logic div_last;  // divider on its final bit
  } status_t;

endpackage

// ----- sv/pkbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// pkbs_ctrl
// Sequencer: accept, optional prep and divide, then emit results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pkbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pkbs_pkg::status_t stat_i,
  output pkbs_pkg::cmd_t    cmd_o
);
  import pkbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.show_new ? ST_PREP : ST_EMIT;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `PKBS_ASSERT_NOW(a_ready_excl_valid, in_ready_o, !out_valid_o)
  `PKBS_ASSERT_NEXT(a_plain_item_emits, cmd_o.accept && !stat_i.show_new, out_valid_o)
  `PKBS_ASSERT_NEXT(a_div_to_emit, state_q == ST_DIV && stat_i.div_last, state_q == ST_EMIT)

endmodule

// ----- sv/pkbs_dp.sv -----
// ----------------------------------------------------------------------------
// pkbs_dp
// Datapath: config registers, button state, divider, frame generation.
// ----------------------------------------------------------------------------
module pkbs_dp #(
  parameter int LED_COUNT = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pkbs_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [pkbs_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                         button_pressed_i,
  input  logic [31:0]                  now_ticks_i,
  input  logic [7:0]                   battery_level_i,
  input  logic                         usb_present_i,
  input  pkbs_pkg::cmd_t               cmd_i,
  output pkbs_pkg::status_t            stat_o,
  output logic                         led_valid_o,
  output logic [3:0]                   led_index_o,
  output logic [7:0]                   led_value_o,
  output logic                         last_o,
  output logic                         led_override_o,
  output logic                         reset_pulse_o,
  output logic                         power_off_o,
  output logic                         airplane_request_o,
  output logic                         low_battery_shutdown_o
);
  import pkbs_pkg::*;

  localparam logic [3:0] LAST_IDX = 4'(LED_COUNT - 1);

  logic [15:0] hold_off_q, hold_air_q;
  logic [7:0]  rel_rst_q, thr_q, fade_per_q;

  logic [1:0]  mode_q, mode_d;
  logic [31:0] press_start_q, press_start_d;
  logic [7:0]  fade_level_q, fade_level_d, fade_count_q, fade_count_d;
  logic        show_q, show_d, ovr_q, ovr_d, rst_q, rst_d;
  logic        poff_q, poff_d, air_q, air_d, lowb_q, lowb_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  bat_q;
  logic [15:0] step_q;
  logic [18:0] amount_q;
  logic        bar_done_q;
  logic [DIV_W-1:0] rem_q, quo_q;
  logic [3:0]  div_cnt_q;
  logic [3:0]  cnt_q;

  logic [31:0] elapsed;
  logic [15:0] span;
  logic [31:0] span_prod;
  logic [15:0] step_q5;
  logic [10:0] scale;
  logic [18:0] amount_new;
  logic [16:0] shifted;
  logic [17:0] trial;
  logic [7:0]  lights;
  logic [15:0] frac_prod;
  logic        in_bar;

  assign elapsed = now_ticks_i - press_start_q;

  // per-item decisions on the poll being accepted
  always_comb begin
    mode_d        = mode_q;
    press_start_d = press_start_q;
    fade_level_d  = fade_level_q;
    fade_count_d  = fade_count_q;
    show_d = 1'b0; ovr_d = 1'b0; rst_d = 1'b0;
    poff_d = 1'b0; air_d = 1'b0; lowb_d = 1'b0;
    left_d = (elapsed >= 32'(hold_air_q)) ? 16'd0 : hold_air_q - elapsed[15:0];
    if (button_pressed_i) begin
      case (mode_q)
        MODE_RESET: begin
          if (elapsed > 32'(hold_off_q)) begin
            mode_d       = MODE_OFF;
            ovr_d        = 1'b1;
            fade_level_d = 8'd0;
          end
        end
        MODE_OFF: begin
          ovr_d  = 1'b1;
          show_d = 1'b1;
          if (fade_count_q >= fade_per_q) begin
            fade_count_d = 8'd0;
            if (fade_level_q != 8'hFF) fade_level_d = fade_level_q + 8'd1;
          end else begin
            fade_count_d = fade_count_q + 8'd1;
          end
          if (elapsed > 32'(hold_air_q)) begin
            poff_d = 1'b1;
            air_d  = 1'b1;
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          press_start_d = now_ticks_i;
          mode_d        = MODE_RESET;
        end
      endcase
    end else begin
      case (mode_q)
        MODE_RESET: begin
          if (elapsed > 32'(rel_rst_q)) begin
            rst_d  = 1'b1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_OFF: begin
          poff_d = 1'b1;
          mode_d = MODE_IDLE;
        end
        default: ;
      endcase
    end
    if (battery_level_i < thr_q && !usb_present_i) begin
      poff_d = 1'b1;
      lowb_d = 1'b1;
      air_d  = (9'(battery_level_i) + 9'd3) < 9'(thr_q);
    end
  end

  // step = (airplane - off) / 5 via reciprocal multiply
  assign span      = (hold_air_q > hold_off_q) ? hold_air_q - hold_off_q : 16'd0;
  assign span_prod = span * RECIP_5;
  assign step_q5   = 16'(span_prod >> 18);
  assign scale     = (thr_q < TOP_LEVEL) ? SCALE_TAB[thr_q[5:0]] : FULL_SCALE;
  assign amount_new = 19'(8'(bat_q - thr_q)) * 19'(scale);

  // restoring divider, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_q    <= 16'd240;
      hold_air_q    <= 16'd2040;
      rel_rst_q     <= 8'd6;
      thr_q         <= 8'd35;
      fade_per_q    <= 8'd40;
      mode_q        <= MODE_IDLE;
      press_start_q <= '0;
      fade_level_q  <= '0;
      fade_count_q  <= '0;
      show_q        <= 1'b0;
      ovr_q         <= 1'b0;
      rst_q         <= 1'b0;
      poff_q        <= 1'b0;
      air_q         <= 1'b0;
      lowb_q        <= 1'b0;
      left_q        <= '0;
      bat_q         <= '0;
      step_q        <= 16'd1;
      amount_q      <= '0;
      bar_done_q    <= 1'b1;
      rem_q         <= '0;
      quo_q         <= '0;
      div_cnt_q     <= '0;
      cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_HOLD_OFF:      hold_off_q <= cfg_wdata_i;
          REG_HOLD_AIRPLANE: hold_air_q <= cfg_wdata_i;
          REG_RELEASE_RESET: rel_rst_q  <= cfg_wdata_i[7:0];
          REG_SHUTDOWN_THR:  thr_q      <= cfg_wdata_i[7:0];
          REG_FADE_PERIOD:   fade_per_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        mode_q        <= mode_d;
        press_start_q <= press_start_d;
        fade_level_q  <= fade_level_d;
        fade_count_q  <= fade_count_d;
        show_q        <= show_d;
        ovr_q         <= ovr_d;
        rst_q         <= rst_d;
        poff_q        <= poff_d;
        air_q         <= air_d;
        lowb_q        <= lowb_d;
        left_q        <= left_d;
        bat_q         <= battery_level_i;
        cnt_q         <= '0;
      end
      if (cmd_i.prep) begin
        step_q     <= (step_q5 == 16'd0) ? 16'd1 : step_q5;
        amount_q   <= amount_new;
        bar_done_q <= (bat_q < thr_q);
        rem_q      <= '0;
        quo_q      <= left_q;
        div_cnt_q  <= 4'(DIV_W - 1);
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - 4'd1;
        if (!trial[17]) begin
          rem_q <= trial[DIV_W-1:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[DIV_W-1:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b0};
        end
      end
      if (cmd_i.advance) begin
        cnt_q <= cnt_q + 4'd1;
        if (in_bar) begin
          if (amount_q > 19'd255) begin
            amount_q <= amount_q - 19'd255;
          end else begin
            bar_done_q <= 1'b1;
          end
        end
      end
    end
  end

  assign lights    = quo_q[7:0] + 8'd1;
  assign in_bar    = show_q && (cnt_q >= BAR_FIRST) && !bar_done_q;
  assign frac_prod = amount_q[7:0] * fade_level_q;

  always_comb begin
    led_value_o = 8'd0;
    if (show_q) begin
      if (cnt_q < TIME_LIGHTS - 4'd1) begin
        led_value_o = ((8'(cnt_q) + 8'd1) < lights) ? LIGHT_ON : 8'd0;
      end else if (cnt_q == TIME_LIGHTS - 4'd1) begin
        led_value_o = (lights != 8'd0) ? LIGHT_ON : 8'd0;
      end else if (in_bar) begin
        led_value_o = (amount_q > 19'd255) ? fade_level_q : frac_prod[15:8];
      end
    end
  end

  assign led_valid_o            = show_q;
  assign led_index_o            = show_q ? cnt_q : 4'd0;
  assign last_o                 = !show_q || (cnt_q == LAST_IDX);
  assign led_override_o         = ovr_q;
  assign reset_pulse_o          = rst_q;
  assign power_off_o            = poff_q;
  assign airplane_request_o     = air_q;
  assign low_battery_shutdown_o = lowb_q;

  assign stat_o.show_new = show_d;
  assign stat_o.last     = last_o;
  assign stat_o.div_last = (div_cnt_q == 4'd0);

endmodule

// ----- sv/power_key_battery_supervisor_top.sv -----
// ----------------------------------------------------------------------------
// power_key_battery_supervisor_top
// Power button and battery supervisor with LED frame output.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   in       | in_valid_i/in_ready_o  | button, tick stamp, battery, usb
//   out      | out_valid_o/out_ready_i| led element and request flags
//   cfg      | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
// A poll without a frame goes from accept straight to a single result.
// A frame poll adds a prep step and the one-bit-per-cycle divider for the
// time-left lights, then emits LED_COUNT results; output stalls add to both.
// One poll at a time; in_ready_o is high only in idle, after the last result is taken.
// Reset is asynchronous and brings registers to their default values.
// ----------------------------------------------------------------------------
module power_key_battery_supervisor_top #(
  parameter int LED_COUNT = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pkbs_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [pkbs_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         button_pressed_i,
  input  logic [31:0]                  now_ticks_i,
  input  logic [7:0]                   battery_level_i,
  input  logic                         usb_present_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         led_valid_o,
  output logic [3:0]                   led_index_o,
  output logic [7:0]                   led_value_o,
  output logic                         last_o,
  output logic                         led_override_o,
  output logic                         reset_pulse_o,
  output logic                         power_off_o,
  output logic                         airplane_request_o,
  output logic                         low_battery_shutdown_o
);
  import pkbs_pkg::*;

  cmd_t    cmd;
  status_t stat;

  pkbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pkbs_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_addr_i             (cfg_addr_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .button_pressed_i       (button_pressed_i),
    .now_ticks_i            (now_ticks_i),
    .battery_level_i        (battery_level_i),
    .usb_present_i          (usb_present_i),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .led_valid_o            (led_valid_o),
    .led_index_o            (led_index_o),
    .led_value_o            (led_value_o),
    .last_o                 (last_o),
    .led_override_o         (led_override_o),
    .reset_pulse_o          (reset_pulse_o),
    .power_off_o            (power_off_o),
    .airplane_request_o     (airplane_request_o),
    .low_battery_shutdown_o (low_battery_shutdown_o)
  );

endmodule
